FILE: sv/fkv_pkg.sv
// Package: sizes, codes, word types and string helpers for the FIFO key-value table.
`timescale 1ns / 1ps
`default_nettype none
package fkv_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int WORD_W  = 64;
    localparam int PTR_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 8 * (KEY_BYTES - 1);
    localparam int QUERY_W = 8 * KEY_BYTES;
    localparam int VAL_W   = 8 * (VALUE_BYTES - 1);
    localparam int ROW_W   = KEY_W + VAL_W;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_INIT  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_INIT  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_ROOM   = 2'd3
    } status_t;

    typedef struct packed {
        req_t               req_type;
        logic [WORD_W-1:0]  entry_key;
        logic [WORD_W-1:0]  put_value;
        logic [7:0]         out_room;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  read_value;
    } out_word_t;

    function automatic logic [WORD_W-1:0] canon(input logic [WORD_W-1:0] s,
                                                input int unsigned maxlen);
        logic [WORD_W-1:0] r;
        logic              alive;
        r     = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (s[WORD_W-1-8*i -: 8] == 8'h00 || i >= maxlen) begin
                alive = 1'b0;
            end
            if (alive) begin
                r[WORD_W-1-8*i -: 8] = s[WORD_W-1-8*i -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] room_mask(input logic [7:0] room);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, room} > 9'(i + 1)) begin
                m[WORD_W-1-8*i -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/fifo_replace_key_value_table_core.sv
// Top level: FIFO-replacement key-value table with request engine and output register.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-----------------------------------------------
//   request | req_valid | req_stall | req: req_type, entry_key, put_value, out_room
//   result  | rsp_valid | rsp_stall | rsp: status, read_value
//
// Put, clear, init and a get with zero room or an empty table go straight from idle
// to the done state; any other get first passes through the scan state, comparing 1 to
// ENTRIES entries in order, one table memory read per cycle.
// Reset empties the table and clears the ready flag; memory contents need no clear
// since only entries below the fill count are ever read.
// A stalled result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module fifo_replace_key_value_table_core
    import fkv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire in_word_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output out_word_t      rsp
);

    logic       res_valid;
    logic       res_take;
    out_word_t  res_word;
    logic       rsp_valid_reg, rsp_valid_next;
    out_word_t  rsp_reg;

    fkv_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_word  (res_word)
    );

    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: sv/fkv_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/fkv_engine.sv
// Request sequencer: table pointers, ready flag, put writes and the one-entry-per-cycle get scan.
`timescale 1ns / 1ps
`default_nettype none
module fkv_engine
    import fkv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire in_word_t  req,
    output logic           res_valid,
    input  wire logic      res_take,
    output out_word_t      res_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    wptr_reg, wptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ready_reg, ready_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [QUERY_W-1:0]  query_reg, query_next;
    logic [WORD_W-1:0]   mask_reg, mask_next;
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   value_reg, value_next;

    logic                wr_en;
    logic [ROW_W-1:0]    wr_data;
    logic [WORD_W-1:0]   key_c;
    logic [WORD_W-1:0]   val_c;
    logic [WORD_W-1:0]   query_c;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    rd_data;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic                hit;
    logic                last;

    fkv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wptr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign key_c   = canon(req.entry_key, KEY_BYTES - 1);
    assign val_c   = canon(req.put_value, VALUE_BYTES - 1);
    assign query_c = canon(req.entry_key, KEY_BYTES);
    assign wr_data = {key_c[WORD_W-1 -: KEY_W], val_c[WORD_W-1 -: VAL_W]};
    assign rd_key  = rd_data[ROW_W-1 -: KEY_W];
    assign rd_val  = rd_data[VAL_W-1:0];
    assign hit     = ({rd_key, 8'h00} == query_reg);
    assign last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_word  = '{status: status_reg, read_value: value_reg};

    always_comb
    begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        count_next  = count_reg;
        ready_next  = ready_reg;
        idx_next    = idx_reg;
        query_next  = query_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        value_next  = value_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = S_DONE;
                    status_next = ST_OK;
                    value_next  = '0;
                    case (req.req_type)
                        REQ_PUT:
                        begin
                            if (ready_reg)
                            begin
                                wr_en = 1'b1;
                                if (wptr_reg == PTR_W'(ENTRIES - 1))
                                begin
                                    wptr_next = '0;
                                end
                                else
                                begin
                                    wptr_next = wptr_reg + PTR_W'(1);
                                end
                                if (count_reg != CNT_W'(ENTRIES))
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                status_next = ST_NOT_INIT;
                            end
                        end
                        REQ_GET:
                        begin
                            if (req.out_room == 8'd0)
                            begin
                                status_next = ST_NO_ROOM;
                            end
                            else if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = '0;
                                query_next = query_c[WORD_W-1 -: QUERY_W];
                                mask_next  = room_mask(req.out_room);
                                state_next = S_SCAN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            wptr_next  = '0;
                            count_next = '0;
                        end
                        REQ_INIT:
                        begin
                            wptr_next  = '0;
                            count_next = '0;
                            ready_next = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_OK;
                    value_next  = {rd_val, {(WORD_W - VAL_W){1'b0}}} & mask_reg;
                    state_next  = S_DONE;
                end
                else if (last)
                begin
                    status_next = ST_NOT_FOUND;
                    value_next  = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + PTR_W'(1);
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wptr_reg  <= '0;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        query_reg  <= query_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

endmodule
`default_nettype wire

FILE: sv/fkv_checker.sv
// Port checker for the FIFO key-value table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fkv_checker
    import fkv_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_stall,
    input wire in_word_t  req,
    input wire logic      rsp_valid,
    input wire logic      rsp_stall,
    input wire out_word_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result word changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
        else $error("nonzero value on a failed request");

    a_value_tail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.read_value[WORD_W-VAL_W-1:0] == '0)
        else $error("value byte beyond stored length is set");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == REQ_GET && req.out_room != 8'd0
        |=> req_stall)
        else $error("scan did not hold off the next request");

endmodule

bind fifo_replace_key_value_table_core fkv_checker u_fkv_checker (.*);
`default_nettype wire
